### rtl/serial_command_line_dispatcher_unit_defines.svh
// assertion helpers shared by the dispatcher rtl
`ifndef SERIAL_COMMAND_LINE_DISPATCHER_UNIT_DEFINES_SVH
`define SERIAL_COMMAND_LINE_DISPATCHER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SCLD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// next-cycle implication, disabled while reset is low
`define SCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dispatcher check failed");

`endif

### rtl/scld_pkg.sv
`default_nettype none

package scld_pkg;

  localparam int BYTE_W     = 8;
  localparam int CMD_IDX_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int M_TDATA_W  = 16;

  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SP  = 8'h20;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_WORD_0    = 3'd1;

endpackage

`default_nettype wire

### rtl/scld_line_store.sv
`default_nettype none

module scld_line_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [AW-1:0]                wr_addr_i,
  input  wire logic [scld_pkg::BYTE_W-1:0]  wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [AW-1:0]                rd_addr_i,
  output logic      [scld_pkg::BYTE_W-1:0]  rd_data_o
);

  logic [scld_pkg::BYTE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/serial_command_line_dispatcher_unit.sv
// Serial command line dispatcher.
// Input stream: one received byte per beat on s_tdata[7:0]. Bytes are stored
// in a line memory until CR or LF; bytes beyond LINE_CHARS are dropped.
// At a line end the first word is compared, in order, against the command
// words written through the configuration port (abbreviations match), and on
// a match the argument bytes leave on the output stream, one per beat, with
// the command index; a line without arguments gives one beat with tuser low.
// tlast marks the final beat of a command. No match gives no beat.
// Throughput: an ordinary byte is taken in one cycle. A line-end byte keeps
// s_tready low while the first word is scanned and the arguments are walked:
// the line memory has one read port with a registered output, so the word
// scan and the argument walk each read one char a cycle, the walk only while
// the output is free. S_SCAN, S_MATCH and S_SKIP precede the first result.
// A stalled receiver holds the output register; the argument walk waits on
// it, and once the last beat is loaded new bytes are accepted again.
// Reset clears the line length, the output valid and the configuration
// (command count zero, so nothing matches until words are written).
`default_nettype none
`include "serial_command_line_dispatcher_unit_defines.svh"

module serial_command_line_dispatcher_unit #(
  parameter int LINE_CHARS   = 32,
  parameter int NUM_COMMANDS = 7,
  parameter int CMD_CHARS    = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [scld_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [scld_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // fields: rx_byte [7:0]
  input  wire logic [scld_pkg::BYTE_W-1:0]         s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // fields: command_index [2:0], arg_byte [10:3], zero fill [15:11]
  output logic      [scld_pkg::M_TDATA_W-1:0]      m_tdata,
  // fields: has_arg [0]
  output logic                                     m_tuser,
  output logic                                     m_tlast
);

  localparam int LW = $clog2(LINE_CHARS + 1);
  localparam int PW = $clog2(LINE_CHARS + 2);
  localparam int IW = $clog2(LINE_CHARS);
  localparam int CW = (CMD_CHARS > 1) ? $clog2(CMD_CHARS) : 1;
  localparam int BW = scld_pkg::BYTE_W;
  localparam int XW = scld_pkg::CMD_IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MATCH = 3'd2;
  localparam logic [2:0] S_SKIP  = 3'd3;
  localparam logic [2:0] S_FIRST = 3'd4;
  localparam logic [2:0] S_NEXT  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [LW-1:0]           len_q, len_d;
  logic [PW-1:0]           pos_q, pos_d, pos_nx, len_ext;
  logic [NUM_COMMANDS-1:0] flag_q, flag_d, char_ok;
  logic [XW-1:0]           idx_q, idx_d, hit_idx, cnt_eff;
  logic                    hit;
  logic [BW-1:0]           cur_q, cur_d;
  logic [XW-1:0]           cmd_count_q;
  logic [BW-1:0]           cmd_char_q [NUM_COMMANDS][CMD_CHARS];

  logic                    m_valid_q;
  logic [XW-1:0]           out_idx_q;
  logic [BW-1:0]           out_byte_q;
  logic                    out_has_q, out_last_q;

  logic                    load, ld_has, ld_last;
  logic [BW-1:0]           ld_byte;
  logic                    rd_en, wr_en;
  logic [IW-1:0]           rd_addr;
  logic [BW-1:0]           rd_data;
  logic                    pos_lt_len, nx_lt_len, out_free, in_acc, is_end;

  scld_line_store #(
    .DEPTH (LINE_CHARS),
    .AW    (IW)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (len_q[IW-1:0]),
    .wr_data_i (s_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_count_q <= '0;
      for (int i = 0; i < NUM_COMMANDS; i++) begin
        for (int k = 0; k < CMD_CHARS; k++) begin
          cmd_char_q[i][k] <= scld_pkg::CHAR_NUL;
        end
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == scld_pkg::REG_COMMAND_COUNT) begin
        cmd_count_q <= cfg_data_i[XW-1:0];
      end
      for (int i = 0; i < NUM_COMMANDS; i++) begin
        if (cfg_index_i == scld_pkg::REG_CMD_WORD_0 + scld_pkg::CFG_IDX_W'(i)) begin
          for (int k = 0; k < CMD_CHARS; k++) begin
            cmd_char_q[i][k] <= cfg_data_i[8*k +: 8];
          end
        end
      end
    end
  end

  assign len_ext    = PW'(len_q);
  assign pos_nx     = pos_q + PW'(1);
  assign pos_lt_len = (pos_q < len_ext);
  assign nx_lt_len  = (pos_nx < len_ext);
  assign out_free   = !m_valid_q || m_tready;
  assign s_tready   = (state_q == S_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign is_end     = (s_tdata == scld_pkg::CHAR_LF) || (s_tdata == scld_pkg::CHAR_CR);
  assign cnt_eff    = (int'(cmd_count_q) > NUM_COMMANDS) ? XW'(NUM_COMMANDS) : cmd_count_q;

  // per-command compare of the char at the scan position
  always_comb begin
    logic [BW-1:0] cc;
    for (int i = 0; i < NUM_COMMANDS; i++) begin
      cc = (int'(pos_q) < CMD_CHARS) ? cmd_char_q[i][pos_q[CW-1:0]] : scld_pkg::CHAR_NUL;
      char_ok[i] = (cc != scld_pkg::CHAR_NUL) && (cc == rd_data);
    end
  end

  // first surviving command below the count
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_COMMANDS - 1; i >= 0; i--) begin
      if (flag_q[i] && (XW'(i) < cnt_eff)) begin
        hit     = 1'b1;
        hit_idx = XW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    pos_d   = pos_q;
    flag_d  = flag_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    rd_en   = 1'b0;
    rd_addr = pos_nx[IW-1:0];
    wr_en   = 1'b0;
    load    = 1'b0;
    ld_byte = scld_pkg::CHAR_NUL;
    ld_has  = 1'b0;
    ld_last = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (is_end) begin
            state_d = S_SCAN;
            pos_d   = '0;
            flag_d  = '1;
            rd_en   = (len_q != '0);
            rd_addr = '0;
          end else if (len_q < LW'(LINE_CHARS)) begin
            wr_en = 1'b1;
            len_d = len_q + LW'(1);
          end
        end
      end
      S_SCAN: begin
        if (!pos_lt_len || (rd_data == scld_pkg::CHAR_SP)) begin
          state_d = S_MATCH;
        end else begin
          flag_d = flag_q & char_ok;
          pos_d  = pos_nx;
          rd_en  = nx_lt_len;
        end
      end
      S_MATCH: begin
        if (hit && (pos_q != '0)) begin
          idx_d   = hit_idx;
          pos_d   = pos_nx;
          rd_en   = nx_lt_len;
          state_d = S_SKIP;
        end else begin
          len_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_SKIP: begin
        // one extra space after the word is dropped
        if (pos_lt_len && (rd_data == scld_pkg::CHAR_SP)) begin
          pos_d = pos_nx;
          rd_en = nx_lt_len;
        end
        state_d = S_FIRST;
      end
      S_FIRST: begin
        if (!pos_lt_len || (rd_data == scld_pkg::CHAR_NUL)) begin
          if (out_free) begin
            load    = 1'b1;
            ld_last = 1'b1;
            len_d   = '0;
            state_d = S_IDLE;
          end
        end else begin
          cur_d   = rd_data;
          pos_d   = pos_nx;
          rd_en   = nx_lt_len;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        // rd_data is the lookahead char that decides last
        if (out_free) begin
          load    = 1'b1;
          ld_byte = cur_q;
          ld_has  = 1'b1;
          ld_last = !pos_lt_len || (rd_data == scld_pkg::CHAR_NUL);
          if (ld_last) begin
            len_d   = '0;
            state_d = S_IDLE;
          end else begin
            cur_d = rd_data;
            pos_d = pos_nx;
            rd_en = nx_lt_len;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        len_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    flag_q <= flag_d;
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    if (load) begin
      out_idx_q  <= idx_q;
      out_byte_q <= ld_byte;
      out_has_q  <= ld_has;
      out_last_q <= ld_last;
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {{(scld_pkg::M_TDATA_W - BW - XW){1'b0}}, out_byte_q, out_idx_q};
  assign m_tuser  = out_has_q;
  assign m_tlast  = out_last_q;

  `SCLD_ASSERT_IMPLIES(a_load_when_free, clk_i, rst_ni, load && m_valid_q, m_tready)
  `SCLD_ASSERT_NEXT(a_end_starts_scan, clk_i, rst_ni, in_acc && is_end, state_q == S_SCAN)
  `SCLD_ASSERT_IMPLIES(a_empty_is_last, clk_i, rst_ni, m_tvalid && !m_tuser, m_tlast)

endmodule

`default_nettype wire

### verif/scld_checker.sv
module scld_checker
  import scld_pkg::*;
#(
  parameter int LINE_CHARS   = 32,
  parameter int NUM_COMMANDS = 7,
  parameter int CMD_CHARS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  output int                    errors_o,
  output int                    pending_o,
  output int                    beats_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CMD_IDX_W-1:0] cmd;
    logic [BYTE_W-1:0]    arg;
    logic                 has_arg;
    logic                 last;
  } arg_beat_t;

  arg_beat_t             expected_args_q[$];
  logic [BYTE_W-1:0]     line_buf[LINE_CHARS];
  int                    line_len;
  logic [CMD_IDX_W-1:0]  cmd_limit;
  logic [CFG_DATA_W-1:0] cmd_table[NUM_COMMANDS];
  int                    err_cnt;
  int                    beat_cnt;

  function automatic logic [BYTE_W-1:0] table_char(int cmd, int pos);
    if (pos >= CMD_CHARS || pos >= 8) return CHAR_NUL;
    return cmd_table[cmd][8*pos +: 8];
  endfunction

  function automatic void report(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  // first word against the table, then queue the argument beats of the hit
  function automatic void match_and_queue_args();
    int word_end;
    int n_cmds;
    int hit;
    int start;
    int stop;
    bit ok;
    logic [BYTE_W-1:0] c;
    arg_beat_t b;
    word_end = 0;
    while (word_end < line_len && line_buf[word_end] != CHAR_SP) word_end++;
    n_cmds = int'(cmd_limit);
    if (n_cmds > NUM_COMMANDS) n_cmds = NUM_COMMANDS;
    hit = -1;
    if (word_end > 0) begin
      for (int i = 0; i < n_cmds && hit < 0; i++) begin
        ok = 1'b1;
        for (int j = 0; j < word_end; j++) begin
          c = table_char(i, j);
          if (c == CHAR_NUL || c != line_buf[j]) ok = 1'b0;
        end
        if (ok) hit = i;
      end
    end
    if (hit < 0) return;
    start = word_end + 1;
    if (start < line_len && line_buf[start] == CHAR_SP) start++;
    stop = start;
    while (stop < line_len && line_buf[stop] != CHAR_NUL) stop++;
    b.cmd = CMD_IDX_W'(hit);
    if (start >= stop) begin
      b.arg = '0;
      b.has_arg = 1'b0;
      b.last = 1'b1;
      expected_args_q.push_back(b);
    end else begin
      for (int k = start; k < stop; k++) begin
        b.arg = line_buf[k];
        b.has_arg = 1'b1;
        b.last = (k + 1 == stop);
        expected_args_q.push_back(b);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    arg_beat_t exp_b;
    arg_beat_t got_b;
    if (!rst_ni) begin
      expected_args_q.delete();
      line_len = 0;
      cmd_limit = '0;
      for (int i = 0; i < NUM_COMMANDS; i++) cmd_table[i] = '0;
      err_cnt = 0;
      beat_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_COMMAND_COUNT) begin
          cmd_limit = cfg_data_i[CMD_IDX_W-1:0];
        end else if (int'(cfg_index_i) - int'(REG_CMD_WORD_0) < NUM_COMMANDS) begin
          cmd_table[int'(cfg_index_i) - int'(REG_CMD_WORD_0)] = cfg_data_i;
        end
      end

      if (m_tvalid && m_tready) begin
        beat_cnt++;
        got_b.cmd = m_tdata[2:0];
        got_b.arg = m_tdata[10:3];
        got_b.has_arg = m_tuser;
        got_b.last = m_tlast;
        if (expected_args_q.size() == 0) begin
          report($sformatf("unexpected beat: cmd %0d arg %02h has %0b last %0b",
                           got_b.cmd, got_b.arg, got_b.has_arg, got_b.last));
        end else begin
          exp_b = expected_args_q.pop_front();
          if (got_b != exp_b)
            report($sformatf({"beat %0d: expected cmd %0d arg %02h has %0b last %0b,",
                              " got cmd %0d arg %02h has %0b last %0b"},
                             beat_cnt, exp_b.cmd, exp_b.arg, exp_b.has_arg, exp_b.last,
                             got_b.cmd, got_b.arg, got_b.has_arg, got_b.last));
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tdata == CHAR_LF || s_tdata == CHAR_CR) begin
          match_and_queue_args();
          line_len = 0;
        end else if (line_len < LINE_CHARS) begin
          line_buf[line_len] = s_tdata;
          line_len++;
        end
      end
    end
    errors_o  <= err_cnt;
    pending_o <= expected_args_q.size();
    beats_o   <= beat_cnt;
  end

endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scld_pkg::*;

  localparam int NUM_CMDS    = 7;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int DRAIN       = 120;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int errors;
  int pending;
  int beats;

  int idle_pct;
  int stall_pct;
  int cycle_cnt;
  int rx_cnt;
  int line_cnt;
  int cfg_cnt;

  logic [CMD_IDX_W-1:0]  cmd_count;
  logic [CFG_DATA_W-1:0] cmd_word[NUM_CMDS];

  serial_command_line_dispatcher_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  scld_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors_o    (errors),
    .pending_o   (pending),
    .beats_o     (beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver side backpressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    rx_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic end_line();
    send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
    line_cnt++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // block must be idle: no beats owed and any unmatched line finished
  task automatic load_table();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    write_reg(REG_COMMAND_COUNT, CFG_DATA_W'(cmd_count));
    for (int i = 0; i < NUM_CMDS; i++) write_reg(REG_CMD_WORD_0 + CFG_IDX_W'(i), cmd_word[i]);
    cfg_cnt++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pack_word(input string s);
    logic [CFG_DATA_W-1:0] w;
    w = '0;
    for (int k = 0; k < s.len() && k < 8; k++) w[8*k +: 8] = s[k];
    return w;
  endfunction

  function automatic int word_len(input logic [CFG_DATA_W-1:0] w);
    for (int k = 0; k < 8; k++) if (w[8*k +: 8] == CHAR_NUL) return k;
    return 8;
  endfunction

  function automatic logic [BYTE_W-1:0] letter();
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  // typable command char: no zero, space or line end
  function automatic logic [BYTE_W-1:0] word_char();
    logic [BYTE_W-1:0] c;
    if ($urandom_range(4) != 0) return letter();
    do c = 8'($urandom_range(1, 255)); while (c == CHAR_SP || c == CHAR_LF || c == CHAR_CR);
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_word(input bit full);
    logic [CFG_DATA_W-1:0] w;
    int n;
    w = '0;
    n = full ? 8 : $urandom_range(1, 8);
    for (int k = 0; k < n; k++) w[8*k +: 8] = word_char();
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] any_char();
    logic [BYTE_W-1:0] c;
    do c = 8'($urandom_range(255)); while (c == CHAR_LF || c == CHAR_CR);
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] arg_char();
    int r;
    r = $urandom_range(19);
    if (r < 15) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 17) return CHAR_SP;
    if (r == 17) return CHAR_NUL;
    return any_char();
  endfunction

  task automatic pick_table(input int seg);
    for (int i = 0; i < NUM_CMDS; i++) cmd_word[i] = random_word($urandom_range(3) == 0);
    case (seg)
      0: begin
        cmd_count = 3'd7;
        cmd_word[6] = '1;
      end
      1: cmd_count = 3'd0;
      7: begin
        // empty first entry and a duplicate: the earlier duplicate must win
        cmd_count = 3'd7;
        cmd_word[0] = '0;
        cmd_word[4] = cmd_word[2];
      end
      default: cmd_count = 3'($urandom_range(1, 7));
    endcase
  endtask

  task automatic send_random_line();
    int mode;
    int pick;
    int wlen;
    int plen;
    int nargs;
    mode = $urandom_range(99);
    if (mode < 78 && cmd_count != 0) begin
      pick = $urandom_range(int'(cmd_count) - 1);
      wlen = word_len(cmd_word[pick]);
      if (wlen == 0) begin
        send_byte(letter());
      end else begin
        plen = $urandom_range(1, wlen);
        for (int k = 0; k < plen; k++) send_byte(cmd_word[pick][8*k +: 8]);
        if ($urandom_range(9) == 0) send_byte(letter());
      end
      if ($urandom_range(9) != 0) begin
        send_byte(CHAR_SP);
        if ($urandom_range(3) == 0) send_byte(CHAR_SP);
        nargs = ($urandom_range(9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 8);
        for (int k = 0; k < nargs; k++) send_byte(arg_char());
      end
    end else begin
      case ($urandom_range(3))
        0: ;
        1: begin
          send_byte(CHAR_SP);
          for (int k = $urandom_range(0, 4); k > 0; k--) send_byte(letter());
        end
        default: for (int k = $urandom_range(1, 10); k > 0; k--) send_byte(any_char());
      endcase
    end
    end_line();
  endtask

  initial begin
    int budget;
    int seg_start;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: abbreviations, doubled space, leading space, empty line,
    // word past the command, zero byte cutting the arguments
    cmd_count = 3'd3;
    cmd_word[0] = pack_word("help");
    cmd_word[1] = pack_word("set");
    cmd_word[2] = pack_word("go");
    for (int i = 3; i < NUM_CMDS; i++) cmd_word[i] = '0;
    load_table();
    send_text("h");
    send_byte(CHAR_CR);
    send_text("se  a");
    send_byte(CHAR_LF);
    send_text(" g");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_text("helpx");
    send_byte(CHAR_CR);
    send_text("go ");
    send_byte(8'hFF);
    send_byte(CHAR_NUL);
    send_text("b");
    send_byte(CHAR_CR);
    line_cnt += 6;

    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      pick_table(seg);
      load_table();
      budget = (seg == 1) ? 15 : 40;
      seg_start = rx_cnt;
      while (rx_cnt - seg_start < budget) send_random_line();
    end

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);

    $display("sent %0d rx bytes in %0d lines over %0d command tables",
             rx_cnt, line_cnt, cfg_cnt);
    $display("checked %0d argument beats, %0d mismatches", beats, errors);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/scld_pkg.sv
rtl/scld_line_store.sv
rtl/serial_command_line_dispatcher_unit.sv
verif/scld_checker.sv
verif/tb_top.sv
